// ===== rtl/core/tpsa_pkg.sv =====
// ----------------------------------------------------------------------------
// tpsa_pkg
// Shared constants, codes and types of the two-ended page slot allocator.
// ----------------------------------------------------------------------------
package tpsa_pkg;

    localparam int PAGE_BYTES         = 8192;
    localparam int SLOT_ENTRY_BYTES   = 16;
    localparam int PAGE_HEADER_BYTES  = 24;
    localparam int LOCAL_HEADER_BYTES = 8;
    localparam int TRAILER_BYTES      = 16;
    localparam int ALIGN              = 8;

    localparam int SLOT_TABLE_BASE =
        ((PAGE_HEADER_BYTES + ALIGN - 1) / ALIGN) * ALIGN +
        ((LOCAL_HEADER_BYTES + ALIGN - 1) / ALIGN) * ALIGN;
    localparam int TRAILER_START =
        PAGE_BYTES - ((TRAILER_BYTES + ALIGN - 1) / ALIGN) * ALIGN;

    localparam logic [13:0] SLOT_BUDGET_RESET = 14'd8144;

    typedef enum logic {
        REQ_ADD    = 1'b0,
        REQ_FINISH = 1'b1
    } req_type_t;

    typedef enum logic [1:0] {
        STATUS_OK          = 2'd0,
        STATUS_BAD_LENGTH  = 2'd1,
        STATUS_OVER_BUDGET = 2'd2
    } status_t;

    typedef struct packed {
        req_type_t   req_type;
        logic [15:0] map_length;
        logic [15:0] extra_length;
        logic        extra_present;
        logic [63:0] key_hash;
    } req_t;

    typedef struct packed {
        status_t     status;
        logic [31:0] page_number;
        logic [8:0]  slot_index;
        logic [12:0] map_offset;
        logic [12:0] extra_offset;
        logic [63:0] slot_key;
        logic        closed_valid;
        logic [9:0]  closed_slots;
        logic [13:0] closed_lower;
        logic [13:0] closed_upper;
    } rsp_t;

    // request to the blob placement unit
    typedef struct packed {
        logic [13:0] top;
        logic [15:0] tbl_limit;
        logic [15:0] mlen;
        logic [15:0] xlen;
    } place_req_t;

    typedef struct packed {
        logic        ok;
        logic [13:0] map_lo;
        logic [13:0] blob_lo;
    } place_res_t;

    function automatic logic [15:0] align_down16(input logic [15:0] x);
        return x - (x % 16'(ALIGN));
    endfunction

    function automatic logic [16:0] align_up17(input logic [15:0] x);
        logic [16:0] t;
        t = {1'b0, x} + 17'(ALIGN - 1);
        return t - (t % 17'(ALIGN));
    endfunction

endpackage

// ===== rtl/core/tpsa_req_if.sv =====
// ----------------------------------------------------------------------------
// tpsa_req_if
// Request channel: valid/ready handshake carrying one request item.
// ----------------------------------------------------------------------------
interface tpsa_req_if;
    import tpsa_pkg::*;

    logic valid;
    logic ready;
    req_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/tpsa_rsp_if.sv =====
// ----------------------------------------------------------------------------
// tpsa_rsp_if
// Result channel: valid/ready handshake carrying one result item.
// ----------------------------------------------------------------------------
interface tpsa_rsp_if;
    import tpsa_pkg::*;

    logic valid;
    logic ready;
    rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/two_ended_page_slot_allocator.sv =====
// ----------------------------------------------------------------------------
// two_ended_page_slot_allocator
// Places variable-length records on fixed-size pages: slot table grows up
// from the content start, blobs grow down from the trailer. Each request
// item yields exactly one result item with the page, slot and offsets, and
// the bounds of a page when the request closed one. Throughput is one item
// per clock while the result side is not stalled; a request item passes an
// input register and then a result register, with the budget check, both
// placement units and the page state update done combinationally between
// them. The page state registers are updated at the same edge as the result
// register, so consecutive items see each other's effect without stalls.
// The user writes slot_budget through cfg_we/cfg_data only while the block
// is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module two_ended_page_slot_allocator (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic [13:0]   cfg_data,
    tpsa_req_if.sink      req,
    tpsa_rsp_if.source    rsp
);
    import tpsa_pkg::*;

    logic [13:0] budget_reg;

    req_t        req_reg;
    logic        req_valid_reg;
    rsp_t        rsp_reg;
    rsp_t        rsp_next;
    logic        rsp_valid_reg;
    logic        advance;

    logic        page_open_reg;
    logic        page_open_next;
    logic [31:0] page_ctr_reg;
    logic [31:0] page_ctr_next;
    logic [9:0]  slots_reg;
    logic [9:0]  slots_next;
    logic [13:0] edge_reg;
    logic [13:0] edge_next;

    place_req_t  empty_req;
    place_res_t  empty_res;
    place_req_t  cur_req;
    place_res_t  cur_res;

    logic [16:0] mlen_up;
    logic [16:0] xlen_up;
    logic [17:0] need;
    logic        over;
    logic [9:0]  eff_slots;
    logic [13:0] eff_edge;
    logic [13:0] cap;
    logic        roll;
    logic [15:0] lower_full;
    logic [15:0] edge_lower;
    logic [13:0] chosen_map;
    logic [13:0] chosen_blob;
    logic [9:0]  base_slots;

    assign advance   = req_valid_reg && (!rsp_valid_reg || rsp.ready);
    assign req.ready = !req_valid_reg || advance;
    assign rsp.valid = rsp_valid_reg;
    assign rsp.data  = rsp_reg;

    // placement on a fresh page, also used after closing a full page
    assign empty_req.top       = 14'(TRAILER_START);
    assign empty_req.tbl_limit = 16'(SLOT_TABLE_BASE + SLOT_ENTRY_BYTES);
    assign empty_req.mlen      = req_reg.map_length;
    assign empty_req.xlen      = req_reg.extra_length;

    assign cur_req.top       = eff_edge;
    assign cur_req.tbl_limit = 16'(SLOT_TABLE_BASE) +
                               16'(eff_slots + 10'd1) * 16'(SLOT_ENTRY_BYTES);
    assign cur_req.mlen      = req_reg.map_length;
    assign cur_req.xlen      = req_reg.extra_length;

    tpsa_place u_place_empty (
        .p_in  (empty_req),
        .p_out (empty_res)
    );

    tpsa_place u_place_cur (
        .p_in  (cur_req),
        .p_out (cur_res)
    );

    always_comb
    begin
        mlen_up   = align_up17(req_reg.map_length);
        xlen_up   = align_up17(req_reg.extra_length);
        need      = 18'(SLOT_ENTRY_BYTES) + {1'b0, mlen_up} +
                    ((req_reg.extra_length != 16'd0) ? {1'b0, xlen_up} : 18'd0);
        over      = (need > {4'd0, budget_reg}) || !empty_res.ok;

        eff_slots = page_open_reg ? slots_reg : 10'd0;
        eff_edge  = page_open_reg ? edge_reg : 14'(TRAILER_START);
        cap       = budget_reg / 14'(SLOT_ENTRY_BYTES);
        roll      = ({4'd0, eff_slots} >= cap) || !cur_res.ok;

        lower_full = 16'(SLOT_TABLE_BASE) + 16'(eff_slots) * 16'(SLOT_ENTRY_BYTES);
        edge_lower = 16'(SLOT_TABLE_BASE) + 16'(slots_reg) * 16'(SLOT_ENTRY_BYTES);

        chosen_map  = roll ? empty_res.map_lo : cur_res.map_lo;
        chosen_blob = roll ? empty_res.blob_lo : cur_res.blob_lo;
        base_slots  = roll ? 10'd0 : eff_slots;

        rsp_next       = '0;
        rsp_next.status = STATUS_OK;
        page_open_next = page_open_reg;
        page_ctr_next  = page_ctr_reg;
        slots_next     = slots_reg;
        edge_next      = edge_reg;

        case (req_reg.req_type)
            REQ_FINISH:
            begin
                if (page_open_reg)
                begin
                    rsp_next.closed_valid = 1'b1;
                    rsp_next.closed_slots = slots_reg;
                    rsp_next.closed_lower = edge_lower[13:0];
                    rsp_next.closed_upper = edge_reg;
                    page_open_next        = 1'b0;
                    page_ctr_next         = page_ctr_reg + 32'd1;
                end
            end
            REQ_ADD:
            begin
                if (req_reg.map_length == 16'd0)
                begin
                    rsp_next.status = STATUS_BAD_LENGTH;
                end
                else if (over)
                begin
                    rsp_next.status = STATUS_OVER_BUDGET;
                end
                else
                begin
                    if (roll)
                    begin
                        rsp_next.closed_valid = 1'b1;
                        rsp_next.closed_slots = eff_slots;
                        rsp_next.closed_lower = lower_full[13:0];
                        rsp_next.closed_upper = eff_edge;
                        page_ctr_next         = page_ctr_reg + 32'd1;
                    end
                    rsp_next.page_number = page_ctr_next;
                    rsp_next.slot_index  = base_slots[8:0];
                    rsp_next.map_offset  = chosen_map[12:0];
                    if ((req_reg.extra_length != 16'd0) && req_reg.extra_present)
                        rsp_next.extra_offset = chosen_blob[12:0];
                    rsp_next.slot_key    = req_reg.key_hash;
                    page_open_next       = 1'b1;
                    slots_next           = base_slots + 10'd1;
                    edge_next            = chosen_blob;
                end
            end
            default:
            begin
                rsp_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            budget_reg <= SLOT_BUDGET_RESET;
        else if (cfg_we)
            budget_reg <= cfg_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
            page_open_reg <= 1'b0;
            page_ctr_reg  <= 32'd0;
            slots_reg     <= 10'd0;
            edge_reg      <= 14'(TRAILER_START);
        end
        else
        begin
            if (req.ready)
                req_valid_reg <= req.valid;
            if (advance)
            begin
                rsp_valid_reg <= 1'b1;
                page_open_reg <= page_open_next;
                page_ctr_reg  <= page_ctr_next;
                slots_reg     <= slots_next;
                edge_reg      <= edge_next;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (req.ready && req.valid)
            req_reg <= req.data;
        if (advance)
            rsp_reg <= rsp_next;
    end
endmodule

// ===== rtl/core/tpsa_place.sv =====
// ----------------------------------------------------------------------------
// tpsa_place
// Carves the main blob and the optional second blob downward from a top
// edge, aligned down, and checks them against the end of the slot table.
// ----------------------------------------------------------------------------
module tpsa_place (
    input  tpsa_pkg::place_req_t p_in,
    output tpsa_pkg::place_res_t p_out
);
    import tpsa_pkg::*;

    logic [15:0] top16;
    logic [15:0] s_al;
    logic [15:0] b_al;
    logic        has_extra;
    logic        fail;

    always_comb
    begin
        top16     = 16'(p_in.top);
        has_extra = (p_in.xlen != 16'd0);
        s_al      = align_down16(top16 - p_in.mlen);
        b_al      = has_extra ? align_down16(s_al - p_in.xlen) : s_al;
        // running below zero counts as a collision
        fail      = (top16 < p_in.mlen) || (has_extra && (s_al < p_in.xlen));

        p_out.ok      = !fail && (b_al >= p_in.tbl_limit);
        p_out.map_lo  = s_al[13:0];
        p_out.blob_lo = b_al[13:0];
    end
endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the two-ended page slot allocator. A driver feeds
// request items from a queue with random gaps. A receiver stalls at random
// and once in a while holds off for a long stretch. Every accepted request
// is run through a local page placement model. Each result item is compared
// field by field with the oldest predicted placement. The slot budget is
// swept through several settings, the extremes among them.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import tpsa_pkg::*;

    localparam longint LIMIT_CYCLES = 1000000;
    localparam int     HOLD_CYCLES  = 500;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic [13:0] cfg_data;

    tpsa_req_if req ();
    tpsa_rsp_if rsp ();

    two_ended_page_slot_allocator dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .req      (req),
        .rsp      (rsp)
    );

    always #4 clk = ~clk;

    // model of the page state
    int          budget_bytes = int'(SLOT_BUDGET_RESET);
    bit          page_active  = 1'b0;
    logic [31:0] page_no      = '0;
    int          slot_count   = 0;
    int          blob_floor   = TRAILER_START;

    req_t request_q[$];
    rsp_t placement_q[$];
    int   mismatches = 0;
    bit   steady     = 1'b0;

    int send_gap;
    int stall_left;
    int hold_left;
    int taken;

    function automatic int ceil_align(int x);
        return ((x + ALIGN - 1) / ALIGN) * ALIGN;
    endfunction

    function automatic int floor_align(int x);
        return x - (x % ALIGN);
    endfunction

    // blobs go below top; fails on underflow or when they drop below tbl_limit
    function automatic bit carve(input int top, input int tbl_limit, input int mlen,
                                 input int xlen, output int map_lo, output int blob_lo);
        map_lo  = 0;
        blob_lo = 0;
        if (top < mlen)
            return 1'b0;
        map_lo  = floor_align(top - mlen);
        blob_lo = map_lo;
        if (xlen > 0)
        begin
            if (map_lo < xlen)
                return 1'b0;
            blob_lo = floor_align(map_lo - xlen);
        end
        return blob_lo >= tbl_limit;
    endfunction

    function automatic void start_page();
        page_active = 1'b1;
        slot_count  = 0;
        blob_floor  = TRAILER_START;
    endfunction

    function automatic void close_page(inout rsp_t o);
        o.closed_valid = 1'b1;
        o.closed_slots = slot_count[9:0];
        o.closed_lower = 14'(SLOT_TABLE_BASE + slot_count * SLOT_ENTRY_BYTES);
        o.closed_upper = blob_floor[13:0];
        page_active    = 1'b0;
        page_no        = page_no + 32'd1;
    endfunction

    function automatic rsp_t place_record(req_t r);
        rsp_t o;
        int   mlen;
        int   xlen;
        int   need;
        int   map_lo;
        int   blob_lo;
        o    = '0;
        mlen = int'(r.map_length);
        xlen = int'(r.extra_length);
        if (r.req_type == REQ_FINISH)
        begin
            if (page_active)
                close_page(o);
            return o;
        end
        if (mlen == 0)
        begin
            o.status = STATUS_BAD_LENGTH;
            return o;
        end
        need = SLOT_ENTRY_BYTES + ceil_align(mlen) + ((xlen > 0) ? ceil_align(xlen) : 0);
        if (need > budget_bytes ||
            !carve(TRAILER_START, SLOT_TABLE_BASE + SLOT_ENTRY_BYTES, mlen, xlen,
                   map_lo, blob_lo))
        begin
            o.status = STATUS_OVER_BUDGET;
            return o;
        end
        if (!page_active)
            start_page();
        // slot cap reached or no room left: move on to a fresh page
        if (slot_count >= budget_bytes / SLOT_ENTRY_BYTES ||
            !carve(blob_floor, SLOT_TABLE_BASE + (slot_count + 1) * SLOT_ENTRY_BYTES,
                   mlen, xlen, map_lo, blob_lo))
        begin
            close_page(o);
            start_page();
            void'(carve(blob_floor, SLOT_TABLE_BASE + SLOT_ENTRY_BYTES, mlen, xlen,
                        map_lo, blob_lo));
        end
        o.status       = STATUS_OK;
        o.page_number  = page_no;
        o.slot_index   = slot_count[8:0];
        o.map_offset   = map_lo[12:0];
        o.extra_offset = (xlen > 0 && r.extra_present) ? blob_lo[12:0] : 13'd0;
        o.slot_key     = r.key_hash;
        blob_floor     = blob_lo;
        slot_count     = (slot_count + 1) & 'h3FF;
        return o;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 65)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        if (r < 99)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic int pick_length(int lim);
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return $urandom_range(1, (lim < 800) ? lim / 4 + 1 : 200);
        if (r < 90)
            return $urandom_range(1, lim / 2 + 1);
        return $urandom_range(1, lim);
    endfunction

    function automatic req_t make_req(req_type_t t, int mlen, int xlen, bit present,
                                      logic [63:0] key);
        req_t q;
        q.req_type      = t;
        q.map_length    = mlen[15:0];
        q.extra_length  = xlen[15:0];
        q.extra_present = present;
        q.key_hash      = key;
        return q;
    endfunction

    function automatic req_t random_req();
        req_t q;
        int   r;
        int   lim;
        q.req_type      = REQ_ADD;
        q.key_hash      = {$urandom, $urandom};
        q.extra_present = 1'($urandom_range(0, 1));
        q.map_length    = 16'($urandom);
        q.extra_length  = 16'($urandom);
        r   = $urandom_range(0, 99);
        lim = budget_bytes - SLOT_ENTRY_BYTES;
        if (lim < 8)
            lim = 8;
        if (r < 4)
            q.req_type = REQ_FINISH;
        else if (r < 7)
            q.map_length = '0;
        else if (r >= 12)
        begin
            // well-formed record sized against the current budget
            q.map_length   = 16'(pick_length(lim));
            q.extra_length = $urandom_range(0, 1) ? 16'd0 : 16'(pick_length(lim / 2));
        end
        return q;
    endfunction

    function automatic string field_diff(string name, logic [63:0] want, logic [63:0] got);
        if (want === got)
            return "";
        return $sformatf(" %s exp %0h got %0h", name, want, got);
    endfunction

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req.valid <= 1'b0;
            req.data  <= '0;
            send_gap  <= 0;
        end
        else if (!(req.valid && !req.ready))
        begin
            if (send_gap > 0)
            begin
                send_gap  <= send_gap - 1;
                req.valid <= 1'b0;
            end
            else if (request_q.size() != 0)
            begin
                req.data  <= request_q.pop_front();
                req.valid <= 1'b1;
                send_gap  <= pick_gap();
            end
            else
                req.valid <= 1'b0;
        end
    end

    // result receiver with random stalls and two long hold-offs
    always @(posedge clk or negedge rst_n)
    begin
        int n;
        if (!rst_n)
        begin
            rsp.ready  <= 1'b0;
            stall_left <= 0;
            hold_left  <= 0;
            taken      <= 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
                taken <= taken + 1;
            if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                rsp.ready <= 1'b0;
            end
            else if (rsp.valid && rsp.ready && (taken == 300 || taken == 1200))
            begin
                hold_left <= HOLD_CYCLES;
                rsp.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left <= stall_left - 1;
                rsp.ready  <= 1'b0;
            end
            else
            begin
                n = pick_gap();
                rsp.ready  <= (n == 0);
                stall_left <= (n > 0) ? n - 1 : 0;
            end
        end
    end

    // predict on request accept, compare on result accept
    always @(posedge clk)
    begin
        rsp_t  want;
        rsp_t  got;
        string diffs;
        if (rst_n)
        begin
            if (req.valid && req.ready)
                placement_q.push_back(place_record(req.data));
            if (rsp.valid && rsp.ready)
            begin
                got = rsp.data;
                if (placement_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: result item with nothing expected, got %h", got);
                end
                else
                begin
                    want  = placement_q.pop_front();
                    diffs = "";
                    diffs = {diffs, field_diff("status", 64'(want.status),
                                               64'(got.status))};
                    diffs = {diffs, field_diff("page_number", 64'(want.page_number),
                                               64'(got.page_number))};
                    diffs = {diffs, field_diff("slot_index", 64'(want.slot_index),
                                               64'(got.slot_index))};
                    diffs = {diffs, field_diff("map_offset", 64'(want.map_offset),
                                               64'(got.map_offset))};
                    diffs = {diffs, field_diff("extra_offset", 64'(want.extra_offset),
                                               64'(got.extra_offset))};
                    diffs = {diffs, field_diff("slot_key", want.slot_key, got.slot_key)};
                    diffs = {diffs, field_diff("closed_valid", 64'(want.closed_valid),
                                               64'(got.closed_valid))};
                    diffs = {diffs, field_diff("closed_slots", 64'(want.closed_slots),
                                               64'(got.closed_slots))};
                    diffs = {diffs, field_diff("closed_lower", 64'(want.closed_lower),
                                               64'(got.closed_lower))};
                    diffs = {diffs, field_diff("closed_upper", 64'(want.closed_upper),
                                               64'(got.closed_upper))};
                    if (diffs != "")
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch at %0t:%s", $realtime, diffs);
                    end
                end
            end
        end
    end

    // settle at the falling edge, where all updates of the rising edge are done
    task automatic wait_idle();
        @(negedge clk);
        while (request_q.size() != 0 || req.valid || placement_q.size() != 0)
            @(negedge clk);
    endtask

    task automatic set_budget(input int value);
        wait_idle();
        repeat (3) @(negedge clk);
        @(posedge clk);
        cfg_we       <= 1'b1;
        cfg_data     <= value[13:0];
        budget_bytes = value;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic push_random(input int n);
        repeat (n) request_q.push_back(random_req());
    endtask

    initial
    begin
        req.valid = 1'b0;
        req.data  = '0;
        rsp.ready = 1'b0;
        cfg_we    = 1'b0;
        cfg_data  = '0;
        rst_n     = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset budget: errors, exact fit, collisions, second blob handling
        steady = 1'b1;
        request_q.push_back(make_req(REQ_FINISH, 0, 0, 1'b0, '0));
        request_q.push_back(make_req(REQ_ADD, 0, 65535, 1'b1, '0));
        request_q.push_back(make_req(REQ_ADD, 1, 0, 1'b1, '1));
        request_q.push_back(make_req(REQ_ADD, 65535, 65535, 1'b1, 64'h5555_5555_5555_5555));
        request_q.push_back(make_req(REQ_ADD, 8129, 0, 1'b0, 64'haaaa_aaaa_aaaa_aaaa));
        request_q.push_back(make_req(REQ_ADD, 8128, 0, 1'b0, 64'h0123_4567_89ab_cdef));
        request_q.push_back(make_req(REQ_ADD, 7, 9, 1'b1, 64'hfedc_ba98_7654_3210));
        request_q.push_back(make_req(REQ_ADD, 100, 33, 1'b0, 64'h1));
        request_q.push_back(make_req(REQ_ADD, 100, 0, 1'b1, 64'h8000_0000_0000_0000));
        request_q.push_back(make_req(REQ_FINISH, 5, 5, 1'b1, '1));
        request_q.push_back(make_req(REQ_FINISH, 0, 0, 1'b0, '0));
        request_q.push_back(make_req(REQ_ADD, 16'haaaa, 16'h5555, 1'b1, '0));
        wait_idle();
        steady = 1'b0;
        push_random(200);

        // widest budget: too big for an empty page, blob underflow
        set_budget(8192);
        request_q.push_back(make_req(REQ_ADD, 8150, 0, 1'b1, 64'h11));
        request_q.push_back(make_req(REQ_ADD, 8120, 0, 1'b1, 64'h22));
        request_q.push_back(make_req(REQ_ADD, 100, 0, 1'b1, 64'h33));
        request_q.push_back(make_req(REQ_ADD, 4000, 4000, 1'b1, 64'h44));
        request_q.push_back(make_req(REQ_FINISH, 0, 0, 1'b0, '0));
        push_random(300);

        // two slots per page, so the slot cap closes pages
        set_budget(32);
        request_q.push_back(make_req(REQ_ADD, 8, 0, 1'b0, 64'h55));
        request_q.push_back(make_req(REQ_ADD, 8, 8, 1'b1, 64'h66));
        request_q.push_back(make_req(REQ_ADD, 8, 0, 1'b1, 64'h77));
        request_q.push_back(make_req(REQ_ADD, 16, 0, 1'b1, 64'h88));
        request_q.push_back(make_req(REQ_ADD, 1, 0, 1'b0, 64'h99));
        request_q.push_back(make_req(REQ_FINISH, 0, 0, 1'b0, '0));
        push_random(60);

        set_budget(0);
        request_q.push_back(make_req(REQ_ADD, 1, 0, 1'b0, 64'hbb));
        request_q.push_back(make_req(REQ_FINISH, 0, 0, 1'b0, '0));
        push_random(30);

        // a stretch without idling on either side
        set_budget(256);
        steady = 1'b1;
        push_random(300);
        wait_idle();
        steady = 1'b0;

        set_budget(1024);
        push_random(250);
        set_budget($urandom_range(0, 8192));
        push_random(200);
        set_budget(int'(SLOT_BUDGET_RESET));
        push_random(300);

        wait_idle();
        repeat (10) @(posedge clk);
        if (mismatches == 0 && placement_q.size() == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

    initial
    begin
        #(LIMIT_CYCLES * 8);
        $display("testbench: errors");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/tpsa_pkg.sv
rtl/core/tpsa_req_if.sv
rtl/core/tpsa_rsp_if.sv
rtl/core/tpsa_place.sv
rtl/core/two_ended_page_slot_allocator.sv
tb/testbench.sv
